// ===== hw/rtl/pwca_pkg.sv =====
// ----------------------------------------------------------------------------
// Pointwise convolution activation package
// Shared constants, register codes, the sigmoid table and saturation helper.
// ----------------------------------------------------------------------------
package pwca_pkg;

  localparam int OUT_CHANNELS = 12;
  localparam int IN_CHANNELS = 4;
  localparam int CH_W = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int SUM_W = 16 + ((IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 0);

  localparam logic [1:0] REG_ACT_MODE = 2'd0;
  localparam logic [1:0] REG_CONV_WEIGHT = 2'd1;
  localparam logic [1:0] REG_CONV_BIAS = 2'd2;

  localparam logic [1:0] MODE_RELU = 2'd0;
  localparam logic [1:0] MODE_SILU = 2'd1;
  localparam logic [1:0] MODE_GELU = 2'd2;

  localparam logic [1:0] RESET_ACT_MODE = MODE_GELU;
  localparam logic signed [15:0] RESET_CONV_WEIGHT = 16'sd307;
  localparam logic signed [15:0] RESET_CONV_BIAS = 16'sd512;

  localparam logic signed [17:0] GELU_LIN = 18'sd104581;
  localparam logic signed [13:0] GELU_CUBE = 14'sd4676;

  typedef struct packed {
    logic [1:0] act_mode;
    logic signed [15:0] conv_weight;
    logic signed [15:0] conv_bias;
  } cfg_t;

  function automatic logic [15:0] sig_tab(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0: v = 16'd32768;
      4'd1: v = 16'd47910;
      4'd2: v = 16'd57724;
      4'd3: v = 16'd62428;
      4'd4: v = 16'd64357;
      4'd5: v = 16'd65097;
      4'd6: v = 16'd65374;
      4'd7: v = 16'd65476;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pointwise_conv_activation_unit.sv =====
// A pixel's first result enters the output register when the pixel leaves the pipeline
// and the prior pixel's results are sent; each pixel sends 12 results over one port.
// The 11-stage pipeline takes a new pixel in every cycle it is not blocked.
// Reset (synchronous, active high) empties the pipeline and the output register and
// restores act_mode 2, conv_weight 307 and conv_bias 512.
// ----------------------------------------------------------------------------
// Pointwise convolution activation unit
// Register port, pipeline instance and the per-channel result sequencer.
// ----------------------------------------------------------------------------
module pointwise_conv_activation_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           chan0_value,
  input  logic signed [15:0]           chan1_value,
  input  logic signed [15:0]           chan2_value,
  input  logic signed [15:0]           chan3_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   out_channel,
  output logic signed [15:0]           out_value,
  output logic                         last_of_pixel,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);

  pwca_pkg::cfg_t cfg;
  logic signed [15:0] chan [pwca_pkg::IN_CHANNELS];
  logic en;
  logic y_valid;
  logic signed [15:0] y;
  logic out_fire;
  logic done;
  logic load;
  logic [pwca_pkg::CH_W-1:0] channel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.act_mode <= pwca_pkg::RESET_ACT_MODE;
      cfg.conv_weight <= pwca_pkg::RESET_CONV_WEIGHT;
      cfg.conv_bias <= pwca_pkg::RESET_CONV_BIAS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwca_pkg::REG_ACT_MODE: cfg.act_mode <= cfg_data[1:0];
        pwca_pkg::REG_CONV_WEIGHT: cfg.conv_weight <= cfg_data;
        pwca_pkg::REG_CONV_BIAS: cfg.conv_bias <= cfg_data;
        default: ;
      endcase
    end
  end

  assign chan[0] = chan0_value;
  assign chan[1] = chan1_value;
  assign chan[2] = chan2_value;
  assign chan[3] = chan3_value;

  assign out_fire = out_valid && !out_stall;
  assign done = !out_valid || (out_fire && last_of_pixel);
  assign load = done && y_valid;
  assign en = !y_valid || load;
  assign in_stall = !en;

  pwca_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .chan     (chan),
    .cfg      (cfg),
    .y_valid  (y_valid),
    .y        (y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      channel <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      channel <= '0;
    end else if (done) begin
      out_valid <= 1'b0;
    end else if (out_fire) begin
      channel <= channel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= y;
    end
  end

  assign out_channel = 4'(channel);
  assign last_of_pixel = (channel == pwca_pkg::CH_W'(pwca_pkg::OUT_CHANNELS - 1));

`ifndef NO_ASSERTIONS
  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (channel <= pwca_pkg::CH_W'(pwca_pkg::OUT_CHANNELS - 1)))
    else $error("result channel beyond the last output channel");

  a_channel_step: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last_of_pixel) |=>
      (out_valid && channel == pwca_pkg::CH_W'($past(channel) + 1'b1)))
    else $error("result channel did not advance by one");

  a_new_pixel: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && channel == '0))
    else $error("new pixel did not start at channel zero");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (y_valid && out_valid))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== hw/rtl/pwca_datapath.sv =====
// ----------------------------------------------------------------------------
// Pointwise convolution activation datapath
// Eleven-stage pipeline from the channel samples to one activated value.
// ----------------------------------------------------------------------------
module pwca_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [15:0]       chan [pwca_pkg::IN_CHANNELS],
  input  pwca_pkg::cfg_t           cfg,
  output logic                     y_valid,
  output logic signed [15:0]       y
);

  logic [10:0] v;

  logic signed [pwca_pkg::SUM_W-1:0] sum1;
  logic signed [33:0] prod2;
  logic signed [15:0] x3;
  logic signed [15:0] x4, x5, x6, x7, x8, x9, x10;
  logic signed [29:0] t4;
  logic signed [33:0] p4, p5, p6;
  logic signed [45:0] t5;
  logic signed [61:0] t6;
  logic signed [31:0] z7;
  logic [15:0] base8;
  logic [13:0] diff8;
  logic [7:0] frac8;
  logic neg8;
  logic [16:0] sig9;
  logic signed [33:0] m10;

  logic signed [pwca_pkg::SUM_W-1:0] sum_next;
  logic signed [35:0] acc_next;
  logic signed [47:0] zsum_next;
  logic signed [31:0] z_next;
  logic [31:0] zabs_next;
  logic [11:0] a_next;
  logic [21:0] step_prod;
  logic [14:0] step_next;
  logic [16:0] s_next;
  logic [16:0] sig_next;
  logic signed [15:0] y_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < pwca_pkg::IN_CHANNELS; i++) begin
      sum_next = sum_next + pwca_pkg::SUM_W'(chan[i]);
    end
    acc_next = (36'(cfg.conv_bias) <<< 8) + 36'(prod2) + 36'sd128;
    zsum_next = 48'(p6) + 48'(t6 >>> 16) + 48'sd32768;
    z_next = (cfg.act_mode == pwca_pkg::MODE_SILU) ? 32'(x6) : 32'(zsum_next >>> 16);
    zabs_next = z7[31] ? 32'(-z7) : z7;
    a_next = (zabs_next > 32'd2048) ? 12'd2048 : zabs_next[11:0];
    step_prod = 22'(diff8) * 22'(frac8);
    step_next = 15'((23'(step_prod) + 23'd128) >> 8);
    s_next = 17'(base8) + 17'(step_next);
    sig_next = neg8 ? 17'h10000 - s_next : s_next;
    case (cfg.act_mode)
      pwca_pkg::MODE_RELU: y_next = x10[15] ? 16'sd0 : x10;
      pwca_pkg::MODE_SILU, pwca_pkg::MODE_GELU:
        y_next = pwca_pkg::sat16((48'(m10) + 48'sd32768) >>> 16);
      default: y_next = x10;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[9:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1 <= sum_next;
      prod2 <= cfg.conv_weight * sum1;
      x3 <= pwca_pkg::sat16(48'(acc_next >>> 8));
      x4 <= x3;
      t4 <= x3 * pwca_pkg::GELU_CUBE;
      p4 <= x3 * pwca_pkg::GELU_LIN;
      x5 <= x4;
      p5 <= p4;
      t5 <= t4 * x4;
      x6 <= x5;
      p6 <= p5;
      t6 <= t5 * x5;
      x7 <= x6;
      z7 <= z_next;
      x8 <= x7;
      neg8 <= z7[31];
      frac8 <= a_next[7:0];
      base8 <= pwca_pkg::sig_tab(a_next[11:8]);
      diff8 <= (a_next[11:8] < 4'd8) ?
               14'(pwca_pkg::sig_tab(a_next[11:8] + 4'd1) - pwca_pkg::sig_tab(a_next[11:8])) :
               14'd0;
      x9 <= x8;
      sig9 <= sig_next;
      x10 <= x9;
      m10 <= x9 * $signed({1'b0, sig9});
      y <= y_next;
    end
  end

  assign y_valid = v[10];

endmodule
